FILE: rtl/core/imusfd_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder package
// Frame constants, scale factors and the frame record passed between stages.
// ----------------------------------------------------------------------------
package imusfd_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	// Byte positions inside the 11-byte frame, counted from zero.
	localparam logic [3:0] POS_TYPE = 4'd1;
	localparam logic [3:0] POS_LO   = 4'd6;
	localparam logic [3:0] POS_HI   = 4'd7;
	localparam logic [3:0] POS_SUM  = 4'd10;

	localparam logic KIND_RATE  = 1'b0;
	localparam logic KIND_ANGLE = 1'b1;

	// Full scale 2000 dps or 180 deg over 32768 counts, in 1/65536 units.
	localparam logic [12:0] RATE_MUL  = 13'd4000;
	localparam logic [12:0] ANGLE_MUL = 13'd360;

	localparam int RAW_W    = 16;
	localparam int SCALED_W = 28;
	localparam int STAMP_W  = 48;

	typedef struct packed {
		logic                     kind;
		logic signed [RAW_W-1:0]  raw;
		logic [STAMP_W-1:0]       stamp;
		logic                     rate_seen;
		logic                     angle_seen;
	} frame_t;

endpackage

FILE: rtl/core/imu_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder
// Assembles 11-byte IMU frames from a byte stream and emits one decoded item
// per frame with a good checksum.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                         Handshake
// s_axis    in   tdata: rx_byte, time_ms                         tvalid/tready
// m_axis    out  tdata: raw_word, scaled_q16, stamp_ms, flags;   tvalid/tready
//                tuser: kind
//
// One byte is accepted every cycle while the output is not stalled; after the
// closing checksum byte is accepted, the result item passes through the input
// register, the parser register and the scaler output register in that order.
// Reset clears the frame position, the seen flags and all valid bits. When a
// result item is held at the output and not taken, the whole pipeline stalls
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // rx_byte[7:0], time_ms[55:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // raw_word[15:0], scaled_q16[43:16], stamp_ms[91:44],
	                                   // rate_seen[92], angle_seen[93], zero[95:94]
	output logic        m_axis_tuser   // kind
);

	logic                                    en;
	logic                                    frm_valid_s2;
	imusfd_pkg::frame_t                      frm_s2;
	logic                                    out_valid_q;
	imusfd_pkg::frame_t                      out_frm_q;
	logic signed [imusfd_pkg::SCALED_W-1:0]  out_scaled_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	imusfd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.in_byte      (s_axis_tdata[7:0]),
		.in_time      (s_axis_tdata[55:8]),
		.frm_valid_s2 (frm_valid_s2),
		.frm_s2       (frm_s2)
	);

	imusfd_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.frm_valid_s2 (frm_valid_s2),
		.frm_s2       (frm_s2),
		.out_valid_q  (out_valid_q),
		.out_frm_q    (out_frm_q),
		.out_scaled_q (out_scaled_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_frm_q.kind;
	assign m_axis_tdata  = {2'b00, out_frm_q.angle_seen, out_frm_q.rate_seen,
	                        out_frm_q.stamp, out_scaled_q, out_frm_q.raw};

endmodule

FILE: rtl/core/imusfd_parser.sv
// ----------------------------------------------------------------------------
// IMU frame parser
// Registers each incoming byte, tracks the frame position and running sum,
// and registers one frame record when a frame closes with a good checksum.
// ----------------------------------------------------------------------------
module imusfd_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [7:0]                        in_byte,
	input  logic [imusfd_pkg::STAMP_W-1:0]    in_time,
	output logic                              frm_valid_s2,
	output imusfd_pkg::frame_t                frm_s2
);

	logic                           valid_s1;
	logic [7:0]                     byte_s1;
	logic [imusfd_pkg::STAMP_W-1:0] time_s1;

	logic [3:0] cnt_q;
	logic [7:0] sum_q;
	logic       kind_q;
	logic [7:0] lo_q;
	logic [7:0] hi_q;
	logic       rate_flag_q;
	logic       angle_flag_q;

	logic       take;
	logic       emit;
	logic [3:0] cnt_d;
	logic [7:0] sum_d;
	logic       kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			byte_s1 <= in_byte;
			time_s1 <= in_time;
		end
	end

	assign take = en && valid_s1;

	// Position decode. A count above the last position is treated as zero.
	always_comb begin
		cnt_d  = cnt_q;
		sum_d  = sum_q;
		kind_d = kind_q;
		emit   = 1'b0;
		if (cnt_q == imusfd_pkg::POS_TYPE) begin
			if (byte_s1 == imusfd_pkg::TYPE_RATE || byte_s1 == imusfd_pkg::TYPE_ANGLE) begin
				cnt_d  = cnt_q + 4'd1;
				sum_d  = sum_q + byte_s1;
				kind_d = (byte_s1 == imusfd_pkg::TYPE_ANGLE) ? imusfd_pkg::KIND_ANGLE
				                                              : imusfd_pkg::KIND_RATE;
			end else if (byte_s1 == imusfd_pkg::HDR_BYTE) begin
				// A header in the type slot starts a new frame.
				cnt_d = 4'd1;
				sum_d = byte_s1;
			end else begin
				cnt_d = 4'd0;
			end
		end else if (cnt_q == imusfd_pkg::POS_SUM) begin
			cnt_d = 4'd0;
			emit  = (byte_s1 == sum_q);
		end else if (cnt_q > imusfd_pkg::POS_TYPE && cnt_q < imusfd_pkg::POS_SUM) begin
			cnt_d = cnt_q + 4'd1;
			sum_d = sum_q + byte_s1;
		end else begin
			if (byte_s1 == imusfd_pkg::HDR_BYTE) begin
				cnt_d = 4'd1;
				sum_d = byte_s1;
			end else begin
				cnt_d = 4'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= 4'd0;
			rate_flag_q  <= 1'b0;
			angle_flag_q <= 1'b0;
			frm_valid_s2 <= 1'b0;
		end else if (en) begin
			frm_valid_s2 <= take && emit;
			if (take) begin
				cnt_q <= cnt_d;
				if (emit) begin
					if (kind_q == imusfd_pkg::KIND_ANGLE) begin
						angle_flag_q <= 1'b1;
					end else begin
						rate_flag_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sum_q  <= sum_d;
			kind_q <= kind_d;
			if (cnt_q == imusfd_pkg::POS_LO) begin
				lo_q <= byte_s1;
			end
			if (cnt_q == imusfd_pkg::POS_HI) begin
				hi_q <= byte_s1;
			end
			if (emit) begin
				frm_s2.kind       <= kind_q;
				frm_s2.raw        <= $signed({hi_q, lo_q});
				frm_s2.stamp      <= time_s1;
				frm_s2.rate_seen  <= rate_flag_q | (kind_q == imusfd_pkg::KIND_RATE);
				frm_s2.angle_seen <= angle_flag_q | (kind_q == imusfd_pkg::KIND_ANGLE);
			end
		end
	end

endmodule

FILE: rtl/core/imusfd_scale.sv
// ----------------------------------------------------------------------------
// IMU frame scaler and output register
// Scales the raw z word to 1/65536 units and holds the result item until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module imusfd_scale (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    frm_valid_s2,
	input  imusfd_pkg::frame_t                      frm_s2,
	output logic                                    out_valid_q,
	output imusfd_pkg::frame_t                      out_frm_q,
	output logic signed [imusfd_pkg::SCALED_W-1:0]  out_scaled_q
);

	logic        [12:0] mul;
	logic signed [imusfd_pkg::RAW_W+13:0] product;

	assign mul     = (frm_s2.kind == imusfd_pkg::KIND_ANGLE) ? imusfd_pkg::ANGLE_MUL
	                                                          : imusfd_pkg::RATE_MUL;
	assign product = frm_s2.raw * $signed({1'b0, mul});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= frm_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && frm_valid_s2) begin
			out_frm_q    <= frm_s2;
			out_scaled_q <= product[imusfd_pkg::SCALED_W-1:0];
		end
	end

endmodule

FILE: verif/tb_imu_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder testbench
// Feeds byte streams of whole, broken and noisy frames and checks each decoded
// item against a cycle-free copy of the frame parser kept in the bench.
// ----------------------------------------------------------------------------
module tb_imu_serial_frame_decoder;

	typedef struct {
		logic               kind;
		logic signed [15:0] raw;
		logic [27:0]        scaled;
		logic [47:0]        stamp;
		logic               rate_seen;
		logic               angle_seen;
	} decoded_t;

	localparam int STEP_LIMIT   = 200000;
	localparam int RANDOM_BYTES = 1440;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;

	// Parser state mirrored in the bench.
	logic [3:0] frame_pos;
	logic [7:0] frame_hold [11];
	logic       rate_flag;
	logic       angle_flag;

	decoded_t pending_frames[$];
	int       errors;
	int       bytes_sent;
	int       cycle_count;
	bit       steady;

	imu_serial_frame_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// Advances the parser by one accepted byte and queues a decoded item when
	// a frame closes with a good checksum.
	task automatic decode_byte(input logic [7:0] b, input logic [47:0] stamp);
		logic [7:0] acc;
		decoded_t   d;
		int         i;
		if (frame_pos > 4'd10)
			frame_pos = 4'd0;
		if (frame_pos == 4'd0 && b != imusfd_pkg::HDR_BYTE)
			return;
		frame_hold[frame_pos] = b;
		frame_pos = frame_pos + 4'd1;
		if (frame_pos == 4'd2 && b != imusfd_pkg::TYPE_RATE &&
				b != imusfd_pkg::TYPE_ANGLE) begin
			// A second header in the type slot starts a new frame.
			frame_pos = (b == imusfd_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
			return;
		end
		if (frame_pos != 4'd11)
			return;
		frame_pos = 4'd0;
		acc = 8'd0;
		for (i = 0; i < 10; i++)
			acc = acc + frame_hold[i];
		if (acc != frame_hold[imusfd_pkg::POS_SUM])
			return;
		d.raw = {frame_hold[imusfd_pkg::POS_HI], frame_hold[imusfd_pkg::POS_LO]};
		if (frame_hold[imusfd_pkg::POS_TYPE] == imusfd_pkg::TYPE_RATE) begin
			d.kind = imusfd_pkg::KIND_RATE;
			d.scaled = 28'(int'(d.raw) * int'(imusfd_pkg::RATE_MUL));
			rate_flag = 1'b1;
		end else begin
			d.kind = imusfd_pkg::KIND_ANGLE;
			d.scaled = 28'(int'(d.raw) * int'(imusfd_pkg::ANGLE_MUL));
			angle_flag = 1'b1;
		end
		d.stamp = stamp;
		d.rate_seen = rate_flag;
		d.angle_seen = angle_flag;
		pending_frames.push_back(d);
	endtask

	function automatic logic [47:0] rand_stamp();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return 48'd0;
		if (pick == 1)
			return {48{1'b1}};
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [15:0] rand_z();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one item and returns in the step in which it is accepted.
	task automatic send_byte(input logic [7:0] b, input logic [47:0] stamp);
		while (!steady && $urandom_range(0, 99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {stamp, b};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_byte(b, stamp);
		bytes_sent++;
	endtask

	// Sends the first len bytes of a frame; payload bytes other than the z word are random.
	task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] z,
			input bit good_sum, input logic [47:0] stamp, input int len = 11);
		logic [7:0] fr [11];
		logic [7:0] acc;
		int         i;
		fr[0] = imusfd_pkg::HDR_BYTE;
		fr[1] = kind_byte;
		for (i = 2; i < 10; i++)
			fr[i] = ($urandom_range(0, 9) == 0) ? imusfd_pkg::HDR_BYTE : 8'($urandom);
		fr[imusfd_pkg::POS_LO] = z[7:0];
		fr[imusfd_pkg::POS_HI] = z[15:8];
		acc = 8'd0;
		for (i = 0; i < 10; i++)
			acc = acc + fr[i];
		fr[imusfd_pkg::POS_SUM] = good_sum ? acc : acc + 8'($urandom_range(1, 255));
		for (i = 0; i < len; i++)
			send_byte(fr[i], (i == 10) ? stamp : rand_stamp());
	endtask

	function automatic logic [7:0] rand_kind_byte();
		return $urandom_range(0, 1) ? imusfd_pkg::TYPE_RATE : imusfd_pkg::TYPE_ANGLE;
	endfunction

	task automatic test_hunt_and_resync();
		send_byte(8'h00, 48'd0);
		send_byte(8'hff, {48{1'b1}});
		// Header followed by a header: the second one opens the frame.
		send_byte(imusfd_pkg::HDR_BYTE, rand_stamp());
		send_frame(imusfd_pkg::TYPE_RATE, 16'h8000, 1'b1, {48{1'b1}});
		send_byte(imusfd_pkg::HDR_BYTE, rand_stamp());
		send_byte(8'h00, rand_stamp());
	endtask

	task automatic test_extremes();
		send_frame(imusfd_pkg::TYPE_ANGLE, 16'h7fff, 1'b1, 48'd0);
		send_frame(imusfd_pkg::TYPE_RATE, 16'h7fff, 1'b0, rand_stamp());
	endtask

	task automatic test_random_streams();
		logic [7:0] t;
		int         pick;
		while (bytes_sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(rand_kind_byte(), rand_z(), $urandom_range(0, 9) != 0,
					rand_stamp());
			end else if (pick < 80) begin
				case ($urandom_range(0, 3))
					0: t = imusfd_pkg::HDR_BYTE;
					1: t = rand_kind_byte();
					default: t = 8'($urandom);
				endcase
				send_byte(t, rand_stamp());
			end else if (pick < 90) begin
				send_frame(rand_kind_byte(), rand_z(), 1'b1, rand_stamp(),
					$urandom_range(1, 10));
			end else begin
				if ($urandom_range(0, 3) == 0)
					t = imusfd_pkg::HDR_BYTE;
				else
					do t = 8'($urandom);
					while (t == imusfd_pkg::TYPE_RATE || t == imusfd_pkg::TYPE_ANGLE);
				send_byte(imusfd_pkg::HDR_BYTE, rand_stamp());
				send_byte(t, rand_stamp());
			end
		end
	endtask

	task automatic test_back_to_back();
		int n;
		steady = 1'b1;
		for (n = 0; n < 30; n++)
			send_frame(rand_kind_byte(), rand_z(), 1'b1, rand_stamp());
		steady = 1'b0;
	endtask

	// Result side: checks each taken item and stalls at random unless steady is set.
	always @(posedge clk) begin
		decoded_t d;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_frames.size() == 0) begin
					report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
				end else begin
					d = pending_frames.pop_front();
					if (m_axis_tuser != d.kind)
						report_mismatch("kind", 64'(m_axis_tuser), 64'(d.kind));
					if (m_axis_tdata[15:0] != d.raw)
						report_mismatch("raw_word", 64'(m_axis_tdata[15:0]),
							64'(d.raw[15:0]));
					if (m_axis_tdata[43:16] != d.scaled)
						report_mismatch("scaled_q16", 64'(m_axis_tdata[43:16]),
							64'(d.scaled));
					if (m_axis_tdata[91:44] != d.stamp)
						report_mismatch("stamp_ms", 64'(m_axis_tdata[91:44]),
							64'(d.stamp));
					if (m_axis_tdata[92] != d.rate_seen)
						report_mismatch("rate_seen", 64'(m_axis_tdata[92]),
							64'(d.rate_seen));
					if (m_axis_tdata[93] != d.angle_seen)
						report_mismatch("angle_seen", 64'(m_axis_tdata[93]),
							64'(d.angle_seen));
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 21);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > STEP_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		frame_pos = 4'd0;
		rate_flag = 1'b0;
		angle_flag = 1'b0;
		errors = 0;
		bytes_sent = 0;
		cycle_count = 0;
		steady = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hunt_and_resync();
		test_extremes();
		test_random_streams();
		test_back_to_back();
		s_axis_tvalid <= 1'b0;

		while (pending_frames.size() != 0)
			@(posedge clk);
		// Leave room for any stray item that is still in the pipeline.
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
